// ----- design/binary_heap_priority_queue_core_assert.svh -----
// assertion macros shared by the heap queue modules
`ifndef BINARY_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BHPQ_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define BHPQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition that must never hold
`define BHPQ_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ----- design/bhpq_pkg.sv -----
// shared types and codes for the binary heap priority queue
`timescale 1ns / 1ps

package bhpq_pkg;

	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 32;
	localparam int ENTRY_W  = 7;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 48;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_DN_LOAD,
		S_DN_CHK,
		S_DN_SEL,
		S_DN_CMP,
		S_TOP_RD,
		S_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic ins_start;
		logic rem_start;
		logic up_rd;
		logic up_move;
		logic put_val;
		logic dn_capture;
		logic dn_rd;
		logic dn_sel;
		logic dn_move;
		logic top_rd;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic at_root;
		logic up_higher;
		logic dn_leaf;
		logic dn_higher;
		logic out_free;
	} dp_sts_t;

endpackage

// ----- design/bhpq_ctrl.sv -----
// sequencer for insert, remove and peek transactions
`timescale 1ns / 1ps
`include "binary_heap_priority_queue_core_assert.svh"

module bhpq_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic [bhpq_pkg::ACTION_W-1:0]  action,
	output logic                           s_tready,
	input  bhpq_pkg::dp_sts_t              sts,
	output bhpq_pkg::dp_cmd_t              cmd
);

	bhpq_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhpq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			bhpq_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d = bhpq_pkg::S_TOP_RD;
					unique case (action)
						bhpq_pkg::ACT_INSERT: begin
							if (!sts.full) begin
								cmd.ins_start = 1'b1;
								state_d = bhpq_pkg::S_UP_CHK;
							end
						end
						bhpq_pkg::ACT_REMOVE: begin
							if (!sts.empty) begin
								cmd.rem_start = 1'b1;
								state_d = bhpq_pkg::S_DN_LOAD;
							end
						end
						default: ;
					endcase
				end
			end
			bhpq_pkg::S_UP_CHK: begin
				if (sts.at_root) begin
					cmd.put_val = 1'b1;
					state_d = bhpq_pkg::S_TOP_RD;
				end else begin
					cmd.up_rd = 1'b1;
					state_d = bhpq_pkg::S_UP_CMP;
				end
			end
			bhpq_pkg::S_UP_CMP: begin
				if (sts.up_higher) begin
					cmd.up_move = 1'b1;
					state_d = bhpq_pkg::S_UP_CHK;
				end else begin
					cmd.put_val = 1'b1;
					state_d = bhpq_pkg::S_TOP_RD;
				end
			end
			bhpq_pkg::S_DN_LOAD: begin
				cmd.dn_capture = 1'b1;
				state_d = bhpq_pkg::S_DN_CHK;
			end
			bhpq_pkg::S_DN_CHK: begin
				if (sts.dn_leaf) begin
					cmd.put_val = 1'b1;
					state_d = bhpq_pkg::S_TOP_RD;
				end else begin
					cmd.dn_rd = 1'b1;
					state_d = bhpq_pkg::S_DN_SEL;
				end
			end
			bhpq_pkg::S_DN_SEL: begin
				cmd.dn_sel = 1'b1;
				state_d = bhpq_pkg::S_DN_CMP;
			end
			bhpq_pkg::S_DN_CMP: begin
				if (sts.dn_higher) begin
					cmd.dn_move = 1'b1;
					state_d = bhpq_pkg::S_DN_CHK;
				end else begin
					cmd.put_val = 1'b1;
					state_d = bhpq_pkg::S_TOP_RD;
				end
			end
			bhpq_pkg::S_TOP_RD: begin
				cmd.top_rd = 1'b1;
				state_d = bhpq_pkg::S_EMIT;
			end
			bhpq_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = bhpq_pkg::S_IDLE;
				end
			end
			default: state_d = bhpq_pkg::S_IDLE;
		endcase
	end

	// a transaction always leaves idle for at least the root read
	`BHPQ_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state_q != bhpq_pkg::S_IDLE, "accepted transaction did not start work")

endmodule

// ----- design/bhpq_datapath.sv -----
// heap memory, sift registers, comparator and result register
`timescale 1ns / 1ps
`include "binary_heap_priority_queue_core_assert.svh"

module bhpq_datapath #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_wdata,
	input  logic [bhpq_pkg::ACTION_W-1:0]    action,
	input  logic [bhpq_pkg::VALUE_W-1:0]     data_value,
	input  bhpq_pkg::dp_cmd_t                cmd,
	output bhpq_pkg::dp_sts_t                sts,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [bhpq_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (DATA_WIDTH > bhpq_pkg::VALUE_W) ? DATA_WIDTH : bhpq_pkg::VALUE_W;
	localparam int PAD_W = bhpq_pkg::M_TDATA_W - bhpq_pkg::VALUE_W - 1
		- bhpq_pkg::ENTRY_W - bhpq_pkg::STATUS_W;

	function automatic logic ranks_above(input logic mode,
		input logic signed [DATA_WIDTH-1:0] a, input logic signed [DATA_WIDTH-1:0] b);
		return mode ? (a > b) : (a < b);
	endfunction

	logic                           order_mode_q;
	logic [CW-1:0]                  count_q;
	logic [AW-1:0]                  pos_q;
	logic [AW-1:0]                  cidx_q;
	logic signed [DATA_WIDTH-1:0]   val_q;
	logic signed [DATA_WIDTH-1:0]   child_q;
	logic signed [DATA_WIDTH-1:0]   rd0_q;
	logic signed [DATA_WIDTH-1:0]   rd1_q;
	logic [DATA_WIDTH-1:0]          mem_q [CAPACITY];
	logic [bhpq_pkg::STATUS_W-1:0]  status_q;

	logic                           out_valid_q;
	logic [bhpq_pkg::VALUE_W-1:0]   out_top_q;
	logic                           out_empty_q;
	logic [bhpq_pkg::ENTRY_W-1:0]   out_count_q;
	logic [bhpq_pkg::STATUS_W-1:0]  out_status_q;

	logic [AW-1:0]                  parent;
	logic [AW:0]                    lchild;
	logic [AW:0]                    rchild;
	logic                           has_right;
	logic                           pick_right;
	logic                           rd_en;
	logic                           wr_en;
	logic [AW-1:0]                  rd0_addr;
	logic [DATA_WIDTH-1:0]          wr_data;
	logic signed [EW-1:0]           in_ext;
	logic signed [EW-1:0]           top_ext;

	assign parent     = (pos_q - AW'(1)) >> 1;
	assign lchild     = {pos_q, 1'b1};
	assign rchild     = lchild + (AW + 1)'(1);
	assign has_right  = rchild < (AW + 1)'(count_q);
	assign pick_right = has_right && ranks_above(order_mode_q, rd1_q, rd0_q);

	// input value sign-extended from 32 bits, then kept to the storage width
	assign in_ext  = EW'($signed(data_value));
	assign top_ext = EW'(rd0_q);

	assign sts.full      = count_q == CW'(CAPACITY);
	assign sts.empty     = count_q == '0;
	assign sts.at_root   = pos_q == '0;
	assign sts.up_higher = ranks_above(order_mode_q, val_q, rd0_q);
	assign sts.dn_leaf   = lchild >= (AW + 1)'(count_q);
	assign sts.dn_higher = ranks_above(order_mode_q, child_q, val_q);
	assign sts.out_free  = !out_valid_q || m_tready;

	assign rd_en = cmd.rem_start || cmd.up_rd || cmd.dn_rd || cmd.top_rd;
	assign wr_en = cmd.up_move || cmd.dn_move || cmd.put_val;

	always_comb begin
		priority if (cmd.rem_start) begin
			rd0_addr = AW'(count_q - CW'(1));
		end else if (cmd.up_rd) begin
			rd0_addr = parent;
		end else if (cmd.dn_rd) begin
			rd0_addr = lchild[AW-1:0];
		end else begin
			rd0_addr = '0;
		end
	end

	always_comb begin
		priority if (cmd.up_move) begin
			wr_data = rd0_q;
		end else if (cmd.dn_move) begin
			wr_data = child_q;
		end else begin
			wr_data = val_q;
		end
	end

	// heap storage, one write port and two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[pos_q] <= wr_data;
		end
		if (rd_en) begin
			rd0_q <= mem_q[rd0_addr];
			rd1_q <= mem_q[rchild[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= 1'b1;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				order_mode_q <= cfg_wdata;
			end
			if (cmd.ins_start) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rem_start) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hole-style sift: the moving value stays in val_q until its slot is found
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (action == bhpq_pkg::ACT_INSERT && sts.full) begin
				status_q <= bhpq_pkg::ST_FULL;
			end else if (action == bhpq_pkg::ACT_REMOVE && sts.empty) begin
				status_q <= bhpq_pkg::ST_EMPTY;
			end else begin
				status_q <= bhpq_pkg::ST_OK;
			end
		end
		if (cmd.ins_start) begin
			val_q <= in_ext[DATA_WIDTH-1:0];
			pos_q <= AW'(count_q);
		end else if (cmd.dn_capture) begin
			val_q <= rd0_q;
			pos_q <= '0;
		end else if (cmd.up_move) begin
			pos_q <= parent;
		end else if (cmd.dn_move) begin
			pos_q <= cidx_q;
		end
		if (cmd.dn_sel) begin
			child_q <= pick_right ? rd1_q : rd0_q;
			cidx_q  <= pick_right ? rchild[AW-1:0] : lchild[AW-1:0];
		end
		if (cmd.emit) begin
			out_top_q    <= sts.empty ? '0 : top_ext[bhpq_pkg::VALUE_W-1:0];
			out_empty_q  <= sts.empty;
			out_count_q  <= bhpq_pkg::ENTRY_W'(count_q);
			out_status_q <= status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_status_q, out_count_q, out_empty_q, out_top_q};

	`BHPQ_ASSERT_NEVER(a_count_in_range, count_q > CW'(CAPACITY), "entry count beyond capacity")
	`BHPQ_ASSERT_IMPL(a_emit_slot_free, cmd.emit, !out_valid_q || m_tready, "result register overwritten while held")
	`BHPQ_ASSERT_NEXT(a_insert_counts, cmd.ins_start, count_q == $past(count_q) + CW'(1), "insert did not add an entry")
	`BHPQ_ASSERT_IMPL(a_no_insert_full, cmd.ins_start, !sts.full, "insert started on a full heap")

endmodule

// ----- design/binary_heap_priority_queue_core.sv -----
// binary heap priority queue: top level joining the sequencer and the datapath
//
//  channel | direction | handshake            | payload
//  s_*     | in        | s_tvalid / s_tready  | s_tuser action, s_tdata data_value
//  m_*     | out       | m_tvalid / m_tready  | m_tdata result fields
//  cfg_*   | in        | cfg_we               | cfg_wdata order_mode
//
// one transaction at a time; peek and rejected operations go from idle to the root read
// insert climbs through the up check and compare states per level, then writes the value
// remove loads the last entry, then checks, selects a child and compares per level descended
// every transaction ends with the root read and emit; the emit state stalls while a result is held
// a finished result waits in the output register while the next item is accepted
// reset empties the heap and puts the largest value on top; no clearing pass
`timescale 1ns / 1ps

module binary_heap_priority_queue_core #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bhpq_pkg::S_TDATA_W-1:0]  s_tdata,  // [31:0] data_value
	input  logic [bhpq_pkg::ACTION_W-1:0]   s_tuser,  // [1:0] action
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [31:0] top_value, [32] heap_empty, [39:33] entry_count, [41:40] status
	output logic [bhpq_pkg::M_TDATA_W-1:0]  m_tdata
);

	bhpq_pkg::dp_cmd_t cmd;
	bhpq_pkg::dp_sts_t sts;

	bhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.action   (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bhpq_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.action     (s_tuser),
		.data_value (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.m_tdata    (m_tdata)
	);

endmodule

// ----- dv/binary_heap_priority_queue_checker.sv -----
// scoreboard for the heap queue: mirrors the heap and checks every result transaction
`timescale 1ns / 1ps

module binary_heap_priority_queue_checker #(
	parameter int CAPACITY = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [bhpq_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] data_value
	input  logic [bhpq_pkg::ACTION_W-1:0]   s_tuser,   // [1:0] action
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// [31:0] top_value, [32] heap_empty, [39:33] entry_count, [41:40] status
	input  logic [bhpq_pkg::M_TDATA_W-1:0]  m_tdata,
	output int                              mismatches,
	output int                              outstanding
);

	typedef struct packed {
		logic signed [bhpq_pkg::VALUE_W-1:0] top;
		logic                                empty;
		logic [bhpq_pkg::ENTRY_W-1:0]        count;
		logic [bhpq_pkg::STATUS_W-1:0]       status;
	} heap_report_t;

	logic signed [bhpq_pkg::VALUE_W-1:0] mirror [CAPACITY];
	int                                  held;
	logic                                max_on_top;
	heap_report_t                        reports_due [$];
	int                                  errs;

	function automatic logic outranks(logic signed [bhpq_pkg::VALUE_W-1:0] a,
			logic signed [bhpq_pkg::VALUE_W-1:0] b);
		return max_on_top ? (a > b) : (a < b);
	endfunction

	task automatic swap_entries(input int i, input int j);
		logic signed [bhpq_pkg::VALUE_W-1:0] tmp;
		tmp = mirror[i];
		mirror[i] = mirror[j];
		mirror[j] = tmp;
	endtask

	task automatic climb(input int start);
		int pos;
		int up;
		pos = start;
		while (pos > 0) begin
			up = (pos - 1) / 2;
			if (!outranks(mirror[pos], mirror[up]))
				return;
			swap_entries(pos, up);
			pos = up;
		end
	endtask

	task automatic descend();
		int pos;
		int c;
		pos = 0;
		forever begin
			c = 2 * pos + 1;
			if (c >= held)
				return;
			if (c + 1 < held && outranks(mirror[c + 1], mirror[c]))
				c = c + 1;
			if (!outranks(mirror[c], mirror[pos]))
				return;
			swap_entries(pos, c);
			pos = c;
		end
	endtask

	task automatic apply_heap_op(input logic [bhpq_pkg::ACTION_W-1:0] act,
			input logic signed [bhpq_pkg::VALUE_W-1:0] val, output heap_report_t r);
		logic [bhpq_pkg::STATUS_W-1:0] st;
		st = bhpq_pkg::ST_OK;
		case (act)
			bhpq_pkg::ACT_INSERT: begin
				if (held >= CAPACITY) begin
					st = bhpq_pkg::ST_FULL;
				end else begin
					mirror[held] = val;
					held = held + 1;
					climb(held - 1);
				end
			end
			bhpq_pkg::ACT_REMOVE: begin
				if (held == 0) begin
					st = bhpq_pkg::ST_EMPTY;
				end else begin
					// last entry to the root, then let it sink
					swap_entries(0, held - 1);
					held = held - 1;
					descend();
				end
			end
			default: ;
		endcase
		r.top = (held > 0) ? mirror[0] : '0;
		r.empty = (held == 0);
		r.count = bhpq_pkg::ENTRY_W'(held);
		r.status = st;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		heap_report_t got;
		heap_report_t want;
		if (!arst_n) begin
			held = 0;
			max_on_top = 1'b1;
			reports_due.delete();
			errs = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// results first: a result never belongs to an item taken at the same edge
			if (m_tvalid && m_tready) begin
				got.top = m_tdata[31:0];
				got.empty = m_tdata[32];
				got.count = m_tdata[39:33];
				got.status = m_tdata[41:40];
				if (reports_due.size() == 0) begin
					errs = errs + 1;
					if (errs <= 10)
						$display("%0t: result with nothing awaited: %s %0d %0b %0d %0d",
							$time, "top empty count status", got.top, got.empty,
							got.count, got.status);
				end else begin
					want = reports_due.pop_front();
					if (got.top !== want.top || got.empty !== want.empty ||
							got.count !== want.count || got.status !== want.status) begin
						errs = errs + 1;
						if (errs <= 10)
							$display("%0t: mismatch: expected top %0d empty %0b count %0d status %0d,",
								$time, want.top, want.empty, want.count, want.status,
								" got top %0d empty %0b count %0d status %0d",
								got.top, got.empty, got.count, got.status);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_heap_op(s_tuser, s_tdata, want);
				reports_due.push_back(want);
			end
			// entries already held are left as they are
			if (cfg_we)
				max_on_top = cfg_wdata;
			mismatches <= errs;
			outstanding <= reports_due.size();
		end
	end

endmodule

// ----- dv/binary_heap_priority_queue_core_tb.sv -----
// testbench top: drives the heap queue, holds the scoreboard and gives the verdict
`timescale 1ns / 1ps

module binary_heap_priority_queue_core_tb;

	// unused code, behaves as a peek
	localparam logic [bhpq_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;
	localparam logic ORDER_MIN = 1'b0;
	localparam logic ORDER_MAX = 1'b1;
	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASES = 14;
	localparam int PHASE_ITEMS = 102;
	localparam int STALL_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic                             cfg_wdata;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [bhpq_pkg::S_TDATA_W-1:0]   s_tdata;
	logic [bhpq_pkg::ACTION_W-1:0]    s_tuser;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [bhpq_pkg::M_TDATA_W-1:0]   m_tdata;

	int   mismatches;
	int   outstanding;
	int   cycles = 0;
	logic calm = 1'b0;
	int   stall_reqs = 0;
	int   stall_done = 0;
	int   stall_left = 0;

	always #4 clk = ~clk;

	binary_heap_priority_queue_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	binary_heap_priority_queue_checker u_score (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_done != stall_reqs) begin
			stall_done <= stall_reqs;
			stall_left <= STALL_CYCLES;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= 30);
		end
	end

	task automatic offer(input logic [bhpq_pkg::ACTION_W-1:0] act,
			input logic [bhpq_pkg::VALUE_W-1:0] val);
		if (!calm && $urandom_range(0, 99) < 30) begin
			s_tvalid <= 1'b0;
			s_tdata <= bhpq_pkg::S_TDATA_W'($urandom);
			s_tuser <= bhpq_pkg::ACTION_W'($urandom);
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait until every result has been taken
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
	endtask

	task automatic set_order(input logic ord);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ord;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [bhpq_pkg::ACTION_W-1:0] pick_action(input int ins_pct,
			input int rem_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			return bhpq_pkg::ACT_INSERT;
		if (roll < ins_pct + rem_pct)
			return bhpq_pkg::ACT_REMOVE;
		return roll[0] ? bhpq_pkg::ACT_PEEK : ACT_SPARE;
	endfunction

	function automatic logic [bhpq_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			// narrow band around zero gives plenty of equal keys
			4, 5: return 32'($urandom_range(0, 15)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	initial begin : stimulus
		int p;
		int k;
		int kind;
		logic ord;
		logic [bhpq_pkg::ACTION_W-1:0] act;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = bhpq_pkg::ACT_PEEK;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset order, largest on top; empty heap cases first
		offer(bhpq_pkg::ACT_PEEK, 32'h0);
		offer(bhpq_pkg::ACT_REMOVE, 32'h1234_5678);
		offer(ACT_SPARE, 32'hffff_ffff);
		offer(bhpq_pkg::ACT_INSERT, 32'h8000_0000);
		offer(bhpq_pkg::ACT_INSERT, 32'h7fff_ffff);
		offer(bhpq_pkg::ACT_INSERT, 32'h0);
		offer(bhpq_pkg::ACT_INSERT, 32'hffff_ffff);
		offer(bhpq_pkg::ACT_PEEK, 32'h5555_5555);
		offer(ACT_SPARE, 32'haaaa_aaaa);
		offer(bhpq_pkg::ACT_INSERT, 32'd5);
		offer(bhpq_pkg::ACT_REMOVE, 32'h0);
		offer(bhpq_pkg::ACT_REMOVE, 32'h0);
		settle();

		// flip to smallest on top with entries still held
		set_order(ORDER_MIN);
		offer(bhpq_pkg::ACT_PEEK, 32'h0);
		offer(bhpq_pkg::ACT_INSERT, 32'd1);
		offer(bhpq_pkg::ACT_REMOVE, 32'h0);
		offer(bhpq_pkg::ACT_REMOVE, 32'h0);
		offer(bhpq_pkg::ACT_REMOVE, 32'h0);
		offer(bhpq_pkg::ACT_REMOVE, 32'h0);
		offer(bhpq_pkg::ACT_INSERT, 32'h7fff_ffff);
		offer(bhpq_pkg::ACT_INSERT, 32'h7fff_ffff);
		offer(bhpq_pkg::ACT_INSERT, 32'h8000_0000);
		offer(bhpq_pkg::ACT_REMOVE, 32'h0);
		offer(bhpq_pkg::ACT_REMOVE, 32'h0);
		offer(bhpq_pkg::ACT_REMOVE, 32'h0);
		settle();

		// fill, mixed and drain phases under changing order
		for (p = 0; p < PHASES; p++) begin
			ord = (p < 2) ? ((p == 0) ? ORDER_MAX : ORDER_MIN) : logic'($urandom_range(0, 1));
			set_order(ord);
			kind = p % 3;
			calm <= (p == 4);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 6 && k == 20)
					stall_reqs <= stall_reqs + 1;
				case (kind)
					0: act = pick_action(80, 12);
					1: act = pick_action(45, 45);
					default: act = pick_action(12, 80);
				endcase
				offer(act, pick_value());
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
